// ===== hdl/msum_pkg.sv =====
// shared types and constants for the matrix product-sum block
`timescale 1ns / 1ps
`default_nettype none
package msum_pkg;

  localparam int SUM_W  = 40;
  localparam int ELEM_MAX_W = 32;
  localparam int POS_W  = 3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_D = 2'd3;

  // operand pair travelling along the cell chain
  typedef struct packed {
    logic                        v;
    logic                        first;
    logic                        last;
    logic [POS_W-1:0]            k;
    logic signed [ELEM_MAX_W-1:0] a;
    logic signed [ELEM_MAX_W-1:0] c;
  } tok_t;

  // element write towards the column stores of the cells
  typedef struct packed {
    logic                  v;
    logic                  is_d;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic [ELEM_MAX_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

// ===== hdl/msum_cell.sv =====
// one column cell: holds a column of B and D and accumulates one result element
`timescale 1ns / 1ps
`default_nettype none
module msum_cell #(
  parameter int KW  = 3,
  parameter int EW  = 16,
  parameter int COL = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire msum_pkg::tok_t                tok_in,
  input  wire msum_pkg::wr_t                 wr,
  input  wire logic                          clr_done,
  output msum_pkg::tok_t                     tok_out,
  output logic signed [msum_pkg::SUM_W-1:0]  acc,
  output logic                               done
);
  import msum_pkg::*;

  localparam int DEPTH = 1 << KW;

  logic [EW-1:0] b_mem [DEPTH];
  logic [EW-1:0] d_mem [DEPTH];

  tok_t                 tok_r;
  logic signed [EW-1:0] b_rd_r, d_rd_r;
  logic signed [EW-1:0] a_e, c_e;
  logic                 s1_v_r, s1_first_r, s1_last_r;
  logic signed [2*EW-1:0] p_ab_r, p_cd_r;
  logic signed [SUM_W-1:0] acc_r, acc_base;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (wr.v && wr.col == POS_W'(COL)) begin
      if (wr.is_d) begin
        d_mem[wr.row[KW-1:0]] <= wr.data[EW-1:0];
      end else begin
        b_mem[wr.row[KW-1:0]] <= wr.data[EW-1:0];
      end
    end
    b_rd_r <= b_mem[tok_in.k[KW-1:0]];
    d_rd_r <= d_mem[tok_in.k[KW-1:0]];
  end

  assign a_e = tok_r.a[EW-1:0];
  assign c_e = tok_r.c[EW-1:0];

  // stage 0: token arrives, column operands read alongside
  // stage 1: both products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      tok_r  <= tok_in;
      s1_v_r <= tok_r.v;
    end
    s1_first_r <= tok_r.first;
    s1_last_r  <= tok_r.last;
    p_ab_r     <= a_e * b_rd_r;
    p_cd_r     <= c_e * d_rd_r;
  end

  assign acc_base = s1_first_r ? '0 : acc_r;

  // stage 2: accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      if (s1_v_r) begin
        acc_r <= acc_base + SUM_W'(p_ab_r) + SUM_W'(p_cd_r);
      end
      if (clr_done) begin
        done_r <= 1'b0;
      end else if (s1_v_r && s1_last_r) begin
        done_r <= 1'b1;
      end
    end
  end

  assign tok_out = tok_r;
  assign acc     = acc_r;
  assign done    = done_r;
endmodule
`default_nettype wire

// ===== hdl/matrix_product_sum.sv =====
// top level: operand stores, row feeder, column cell chain and result emitter
// compute: each row is fed through the cell chain, then its n results are
//   emitted in column order, subject to output stalls
// throughput: load transactions one per cycle while idle; a compute transaction
//   holds the input for the whole n-row walk of feed, wait and emit
// reset: rst_n synchronous active low; clears control, sets matrix_size to 8;
//   operand stores hold no defined value until written
`timescale 1ns / 1ps
`default_nettype none
module matrix_product_sum #(
  parameter int MAX_SIZE      = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input transactions
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                in_opcode,
  input  wire logic [1:0]                          in_matrix_select,
  input  wire logic [2:0]                          in_row,
  input  wire logic [2:0]                          in_col,
  input  wire logic signed [15:0]                  in_value,
  // result transactions
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               out_row,
  output logic [2:0]                               out_col,
  output logic signed [msum_pkg::SUM_W-1:0]        out_sum,
  output logic                                     out_last,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [3:0]                          cfg_matrix_size
);
  import msum_pkg::*;

  localparam int KW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int EW = ELEMENT_WIDTH;
  localparam int AW = 2 * KW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FEED = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  // configuration register, always writable
  logic [3:0] size_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 4'd8;
    end else if (cfg_valid) begin
      size_r <= cfg_matrix_size;
    end
  end

  // effective size: zero acts as one, oversize clips to the maximum
  logic [KW-1:0] nm1;
  always_comb begin
    if (size_r == 4'd0) begin
      nm1 = '0;
    end else if (size_r > 4'(MAX_SIZE)) begin
      nm1 = KW'(MAX_SIZE - 1);
    end else begin
      nm1 = KW'(size_r - 4'd1);
    end
  end

  logic [1:0]    state_r;
  logic [KW-1:0] r_r, k_r, c_r;

  assign in_ready = (state_r == ST_IDLE);

  // load decode; positions beyond the store are dropped
  logic                 in_acc, load_ok, start;
  logic signed [EW-1:0] in_elem;
  assign in_acc  = in_valid && in_ready;
  assign load_ok = in_acc && (in_opcode == OP_LOAD) &&
                   ({1'b0, in_row} < 4'(MAX_SIZE)) && ({1'b0, in_col} < 4'(MAX_SIZE));
  assign start   = in_acc && (in_opcode == OP_COMPUTE);
  assign in_elem = EW'(in_value);

  // row operands A and C live here, columns of B and D live in the cells
  logic [EW-1:0] a_mem [1 << AW];
  logic [EW-1:0] c_mem [1 << AW];
  logic signed [EW-1:0] a_rd_r, c_rd_r;

  always_ff @(posedge clk) begin
    if (load_ok && in_matrix_select == SEL_A) begin
      a_mem[{in_row[KW-1:0], in_col[KW-1:0]}] <= in_elem;
    end
    if (load_ok && in_matrix_select == SEL_C) begin
      c_mem[{in_row[KW-1:0], in_col[KW-1:0]}] <= in_elem;
    end
    a_rd_r <= a_mem[{r_r, k_r}];
    c_rd_r <= c_mem[{r_r, k_r}];
  end

  wr_t wr;
  assign wr.v    = load_ok && (in_matrix_select == SEL_B || in_matrix_select == SEL_D);
  assign wr.is_d = (in_matrix_select == SEL_D);
  assign wr.row  = in_row;
  assign wr.col  = in_col;
  assign wr.data = ELEM_MAX_W'(in_elem);

  // feed stage lines up with the registered store read
  logic         feed_v_r, feed_first_r, feed_last_r;
  logic [KW-1:0] feed_k_r;
  tok_t         feed_tok;

  assign feed_tok.v     = feed_v_r;
  assign feed_tok.first = feed_first_r;
  assign feed_tok.last  = feed_last_r;
  assign feed_tok.k     = POS_W'(feed_k_r);
  assign feed_tok.a     = ELEM_MAX_W'(a_rd_r);
  assign feed_tok.c     = ELEM_MAX_W'(c_rd_r);

  // cell chain: tokens step one cell per cycle
  tok_t                    chain [MAX_SIZE];
  logic signed [SUM_W-1:0] cell_acc [MAX_SIZE];
  logic [MAX_SIZE-1:0]     cell_done, col_mask;
  logic                    clr_done;

  for (genvar j = 0; j < MAX_SIZE; j++) begin : g_cell
    msum_cell #(.KW(KW), .EW(EW), .COL(j)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .tok_in   ((j == 0) ? feed_tok : chain[(j == 0) ? 0 : j - 1]),
      .wr       (wr),
      .clr_done (clr_done),
      .tok_out  (chain[j]),
      .acc      (cell_acc[j]),
      .done     (cell_done[j])
    );
    assign col_mask[j] = (KW'(j) <= nm1);
  end

  logic all_done;
  assign all_done = &(cell_done | ~col_mask);

  logic emit_go;
  assign emit_go  = (state_r == ST_EMIT) && (!out_valid || out_ready);
  assign clr_done = emit_go && (c_r == nm1);

  // sequencer: feed a row, wait for the chain, emit the row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      r_r       <= '0;
      k_r       <= '0;
      c_r       <= '0;
      feed_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      feed_v_r <= (state_r == ST_FEED);
      // result register: loaded on emit, emptied when the transaction is taken
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            r_r     <= '0;
            k_r     <= '0;
            c_r     <= '0;
            state_r <= ST_FEED;
          end
        end
        ST_FEED: begin
          if (k_r == nm1) begin
            state_r <= ST_WAIT;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_WAIT: begin
          if (all_done) begin
            c_r     <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (c_r == nm1) begin
              k_r <= '0;
              if (r_r == nm1) begin
                state_r <= ST_IDLE;
              end else begin
                r_r     <= r_r + 1'b1;
                state_r <= ST_FEED;
              end
            end else begin
              c_r <= c_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    feed_k_r     <= k_r;
    feed_first_r <= (k_r == '0);
    feed_last_r  <= (k_r == nm1);
    if (emit_go) begin
      out_row  <= 3'(r_r);
      out_col  <= 3'(c_r);
      out_sum  <= cell_acc[c_r];
      out_last <= (r_r == nm1) && (c_r == nm1);
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_matrix_product_sum.sv =====
// self-checking testbench for the matrix product-sum block
`timescale 1ns / 1ps
`default_nettype none
module tb_matrix_product_sum;
  import msum_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_LOAD;
  logic [1:0] in_matrix_select = SEL_A;
  logic [2:0] in_row = '0;
  logic [2:0] in_col = '0;
  logic signed [15:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_row;
  logic [2:0] out_col;
  logic signed [SUM_W-1:0] out_sum;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_matrix_size = 4'd8;

  // one expected result element
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic signed [SUM_W-1:0] sum;
    logic last;
  } result_t;

  // predictor state: operand planes and current size
  logic signed [15:0] operands [4][8][8];
  logic [3:0] size_reg;
  result_t expected_q [$];
  int errors = 0;
  bit out_gaps = 1'b1;

  always #4 clk = ~clk;

  matrix_product_sum dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_opcode, .in_matrix_select, .in_row, .in_col, .in_value,
    .out_valid, .out_ready, .out_row, .out_col, .out_sum, .out_last,
    .cfg_valid, .cfg_ready, .cfg_matrix_size
  );

  // effective size after clamping of 0 and values above the maximum
  function automatic int eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > 8) return 8;
    return int'(size_reg);
  endfunction

  // predict the whole result matrix of a compute transaction
  task automatic predict_product();
    int n;
    result_t res;
    logic signed [SUM_W-1:0] acc;
    n = eff_size();
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          acc += SUM_W'(operands[SEL_A][r][k]) * SUM_W'(operands[SEL_B][k][c]);
          acc += SUM_W'(operands[SEL_C][r][k]) * SUM_W'(operands[SEL_D][k][c]);
        end
        res.row = r[2:0];
        res.col = c[2:0];
        res.sum = acc;
        res.last = (r == n - 1) && (c == n - 1);
        expected_q.push_back(res);
      end
    end
  endtask

  // send one transaction, waiting a random gap first when gaps is set; valid stays high when
  // the next transaction follows with no gap
  task automatic send_item(input logic op, input logic [1:0] sel, input logic [2:0] r,
                           input logic [2:0] c, input logic signed [15:0] v,
                           input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_matrix_select <= sel;
    in_row <= r;
    in_col <= c;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // accepted at this edge: update the predictor
    if (op == OP_LOAD) begin
      operands[sel][r][c] = v;
    end else begin
      predict_product();
    end
  endtask

  task automatic load(input logic [1:0] sel, input int r, input int c,
                      input logic signed [15:0] v, input bit gaps = 1'b1);
    send_item(OP_LOAD, sel, r[2:0], c[2:0], v, gaps);
  endtask

  // compute with junk in the ignored fields
  task automatic compute();
    send_item(OP_COMPUTE, 2'($urandom), 3'($urandom), 3'($urandom), 16'($urandom));
  endtask

  // wait for all results, then for the block to drain
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_size(input logic [3:0] s);
    cfg_valid <= 1'b1;
    cfg_matrix_size <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = s;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result row %0d col %0d sum %0d", $time,
                 out_row, out_col, out_sum);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_row !== exp_r.row) begin
          $display("%0t: row expected %0d actual %0d", $time, exp_r.row, out_row);
          errors++;
        end
        if (out_col !== exp_r.col) begin
          $display("%0t: col expected %0d actual %0d", $time, exp_r.col, out_col);
          errors++;
        end
        if (out_sum !== exp_r.sum) begin
          $display("%0t: sum expected %0d actual %0d", $time, exp_r.sum, out_sum);
          errors++;
        end
        if (out_last !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, out_last);
          errors++;
        end
      end
    end
  end

  // while out_gaps is set, each result waits a random gap before ready rises
  initial begin
    int wait_n;
    forever begin
      wait_n = out_gaps ? $urandom_range(0, 19) : 0;
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // extremes at size 8 with everything loaded back to back
  task automatic test_extremes();
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        load(SEL_A, r, c, 16'sh8000, 1'b0);
        load(SEL_B, r, c, 16'sh8000, 1'b0);
        load(SEL_C, r, c, 16'sh7fff, 1'b0);
        load(SEL_D, r, c, 16'sh8000, 1'b0);
      end
    compute();
    drain();
  endtask

  // size 0 acts as 1, size above the maximum acts as the maximum
  task automatic test_size_clamp();
    write_size(4'd0);
    load(SEL_A, 0, 0, 16'sh7fff);
    load(SEL_B, 0, 0, 16'sh7fff);
    compute();
    drain();
    write_size(4'd15);
    compute();
    drain();
    write_size(4'd1);
    // load beyond the size is stored and used once it grows
    load(SEL_D, 1, 1, 16'sh1234);
    compute();
    drain();
    write_size(4'd2);
    compute();
    drain();
  endtask

  // random sizes, random loads and computes
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      out_gaps = (ph != 3);
      write_size(ph == 0 ? 4'd8 : 4'($urandom_range(0, 15)));
      for (int i = 0; i < 2; i++)
        load(2'($urandom), $urandom_range(0, 7), $urandom_range(0, 7),
             16'($urandom), ph != 3);
      if (ph % 2 == 0) compute();
      compute();
      drain();
    end
    out_gaps = 1'b1;
  endtask

  initial begin
    size_reg = 4'd8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_size_clamp();
    test_random();
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** matrix_product_sum: PASSED **");
    end else begin
      $display("** matrix_product_sum: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("** matrix_product_sum: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/msum_pkg.sv
hdl/msum_cell.sv
hdl/matrix_product_sum.sv
tb/tb_matrix_product_sum.sv
